FILE: src/zwt_pkg.sv
// Shared types, constants and character tables of the Z-character word tokenizer.
package zwt_pkg;

   localparam int LINE_LENGTH_DEFAULT    = 255;
   localparam int ZCHARS_PER_WORD_DEFAULT = 6;
   localparam int MAX_SEPARATORS_DEFAULT = 8;

   localparam int ZCHAR_W = 5;

   localparam logic [ZCHAR_W-1:0] PAD_CODE    = 5'd5;
   localparam logic [ZCHAR_W-1:0] SHIFT_UP    = 5'd4;
   localparam logic [ZCHAR_W-1:0] SHIFT_PUNCT = 5'd5;
   localparam logic [ZCHAR_W-1:0] ESCAPE_CODE = 5'd6;
   localparam logic [ZCHAR_W-1:0] ALPHA_BASE  = 5'd6;
   localparam logic [15:0]        END_BIT     = 16'h8000;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SEPARATOR_BYTES = 2'd0;
   localparam csr_index_type CSR_SEPARATOR_COUNT = 2'd1;
   localparam csr_index_type CSR_FIRST_VERSION   = 2'd2;

   typedef logic [ZCHAR_W-1:0] zchar_type;

   // Up to four Z-characters produced by one input byte.
   typedef struct packed {
      logic [3:0][ZCHAR_W-1:0] codes;
      logic [2:0]              count;
   } char_codes_type;

   typedef struct packed {
      logic [31:0] packed_code;
      logic [7:0]  word_length;
      logic [7:0]  start_position;
      logic        last_of_run;
   } rsp_item_type;

   // Position of a byte in the punctuation row, or zero when it is not there.
   // Slot zero of the row is the space or escape slot and never matches.
   function automatic zchar_type punct_index(input logic [7:0] c, input logic v1);
      zchar_type k;
      k = '0;
      case (c) inside
         [8'h30:8'h39]: k = 5'(c - 8'h30) + (v1 ? 5'd1 : 5'd2);
         8'h0A: k = v1 ? 5'd0 : 5'd1;
         8'h2E: k = v1 ? 5'd11 : 5'd12;
         8'h2C: k = v1 ? 5'd12 : 5'd13;
         8'h21: k = v1 ? 5'd13 : 5'd14;
         8'h3F: k = v1 ? 5'd14 : 5'd15;
         8'h5F: k = v1 ? 5'd15 : 5'd16;
         8'h23: k = v1 ? 5'd16 : 5'd17;
         8'h27: k = v1 ? 5'd17 : 5'd18;
         8'h22: k = v1 ? 5'd18 : 5'd19;
         8'h2F: k = v1 ? 5'd19 : 5'd20;
         8'h5C: k = v1 ? 5'd20 : 5'd21;
         8'h3C: k = v1 ? 5'd21 : 5'd0;
         8'h2D: k = 5'd22;
         8'h3A: k = 5'd23;
         8'h28: k = 5'd24;
         8'h29: k = 5'd25;
         default: k = '0;
      endcase
      return k;
   endfunction

   // Z-characters for one byte of a word.
   function automatic char_codes_type char_codes(input logic [7:0] c, input logic v1);
      char_codes_type r;
      zchar_type      k;
      r = '0;
      k = punct_index(c, v1);
      case (c) inside
         [8'h61:8'h7A]: begin
            r.codes[0] = 5'(c - 8'h61) + ALPHA_BASE;
            r.count    = 3'd1;
         end
         [8'h41:8'h5A]: begin
            r.codes[0] = SHIFT_UP;
            r.codes[1] = 5'(c - 8'h41) + ALPHA_BASE;
            r.count    = 3'd2;
         end
         default: begin
            r.codes[0] = SHIFT_PUNCT;
            if (k != '0) begin
               r.codes[1] = k + ALPHA_BASE;
               r.count    = 3'd2;
            end else begin
               r.codes[1] = ESCAPE_CODE;
               r.codes[2] = {2'b00, c[7:5]};
               r.codes[3] = c[4:0];
               r.count    = 3'd4;
            end
         end
      endcase
      return r;
   endfunction

endpackage

FILE: src/zwt_if.sv
// Channel interfaces of the tokenizer: byte requests, token responses and register writes.
interface zwt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_line;
   modport source (output valid, output char_byte, output end_of_line, input ready);
   modport sink (input valid, input char_byte, input end_of_line, output ready);
endinterface

interface zwt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] packed_code;
   logic [7:0]  word_length;
   logic [7:0]  start_position;
   logic        last_of_run;
   modport source (output valid, output packed_code, output word_length,
                   output start_position, output last_of_run, input ready);
   modport sink (input valid, input packed_code, input word_length,
                 input start_position, input last_of_run, output ready);
endinterface

interface zwt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/zchar_word_tokenizer.sv
// Top level of the Z-character word tokenizer: byte intake, word encoding and result queue.
//
// A command line enters on the req channel one byte per beat, with end_of_line set on
// the last byte. Space and NUL end a word; a configured separator ends a word and is a
// one-byte token of its own. Each token leaves on the rsp channel as one beat carrying
// its two packed 16-bit Z-character words, its full length, its one-based start and a
// flag on the last token caused by a given byte.
// The csr channel writes the separator bytes, the separator count and the alphabet
// choice; it is always ready and should only be used while the block is idle.
// A token is queued as the byte that completes it is accepted and is presented on rsp
// once earlier results are taken. One byte is accepted every cycle as long as at most two
// results are waiting; a byte that yields two tokens (a pending word and a separator)
// needs two rsp beats, so the four-entry result queue keeps the sustained figure at one
// byte per cycle, falling only while results back up behind a stalled receiver.
// When the receiver stalls the queue fills and req.ready drops once three results wait,
// so nothing is ever lost. Synchronous reset clears the configuration and word registers,
// empties the queue and fills the word buffer with pad characters.
module zchar_word_tokenizer #(
   parameter int LINE_LENGTH     = zwt_pkg::LINE_LENGTH_DEFAULT,
   parameter int ZCHARS_PER_WORD = zwt_pkg::ZCHARS_PER_WORD_DEFAULT,
   parameter int MAX_SEPARATORS  = zwt_pkg::MAX_SEPARATORS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   zwt_req_if.sink   req,
   zwt_rsp_if.source rsp,
   zwt_csr_if.sink   csr
);
   import zwt_pkg::*;

   localparam int FILL_W  = $clog2(ZCHARS_PER_WORD + 1);
   localparam int WORDS   = (ZCHARS_PER_WORD + 2) / 3;
   localparam int PACK_W  = WORDS * 16;
   localparam int QDEPTH  = 4;

   typedef logic [ZCHARS_PER_WORD-1:0][ZCHAR_W-1:0] zbuf_type;

   // Pack the buffer three characters to a word, first word highest, end bit on the
   // last word. With more than six characters only the low 32 bits survive.
   function automatic logic [31:0] pack_word(input zbuf_type zb);
      logic [PACK_W-1:0] v;
      zchar_type         z;
      v = '0;
      for (int w = 0; w < WORDS; w++) begin
         for (int j = 0; j < 3; j++) begin
            z = (w * 3 + j < ZCHARS_PER_WORD) ? zb[w * 3 + j] : PAD_CODE;
            v[(WORDS - 1 - w) * 16 + (2 - j) * ZCHAR_W +: ZCHAR_W] = z;
         end
         if (w == WORDS - 1) begin
            v[(WORDS - 1 - w) * 16 +: 16] = v[(WORDS - 1 - w) * 16 +: 16] | END_BIT;
         end
      end
      return v[31:0];
   endfunction

   // Append new characters after the current fill, dropping what does not fit.
   function automatic zbuf_type merge(input zbuf_type base, input logic [FILL_W-1:0] fill,
                                      input char_codes_type cc);
      zbuf_type r;
      int       off;
      r = base;
      for (int i = 0; i < ZCHARS_PER_WORD; i++) begin
         off = i - int'(fill);
         if (off >= 0 && off < int'(cc.count)) begin
            r[i] = cc.codes[2'(off)];
         end
      end
      return r;
   endfunction

   // Configuration registers.
   logic [63:0] sep_bytes_ff;
   logic [3:0]  sep_count_ff;
   logic        first_version_ff;

   // Word state.
   zbuf_type          zbuf_ff, zbuf_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        length_ff, length_in;
   logic [7:0]        start_ff, start_in;
   logic [7:0]        line_pos_ff, line_pos_in;

   // Result queue; entry zero is the one on the rsp port.
   rsp_item_type q_ff [QDEPTH];
   rsp_item_type q_in [QDEPTH];
   logic [2:0]   count_ff, count_in;

   logic           req_beat, rsp_beat;
   logic [7:0]     c;
   logic [7:0]     pos;
   logic           is_blank, is_sep, pending;
   logic [3:0]     sep_limit;
   char_codes_type cc;
   zbuf_type       tok_base, tok_buf;
   logic [FILL_W-1:0] tok_fill_base, tok_fill;
   logic [FILL_W:0]   fill_sum;
   logic [7:0]     tok_length, tok_start;
   rsp_item_type   pend_item, tok_item, res0, res1;
   logic [1:0]     nres;
   logic           clear_word;
   logic [2:0]     base_count;

   assign c        = req.char_byte;
   assign req_beat = req.valid && req.ready;
   assign rsp_beat = rsp.valid && rsp.ready;
   assign csr.ready = 1'b1;

   // Room for the two results a byte can cause.
   assign req.ready = (count_ff <= 3'd2);

   assign rsp.valid          = (count_ff != 3'd0);
   assign rsp.packed_code    = q_ff[0].packed_code;
   assign rsp.word_length    = q_ff[0].word_length;
   assign rsp.start_position = q_ff[0].start_position;
   assign rsp.last_of_run    = q_ff[0].last_of_run;

   always_comb begin
      pos = (line_pos_ff < 8'(LINE_LENGTH)) ? line_pos_ff + 8'd1 : 8'(LINE_LENGTH);

      is_blank  = (c == 8'h00) || (c == 8'h20);
      sep_limit = (sep_count_ff > 4'(MAX_SEPARATORS)) ? 4'(MAX_SEPARATORS) : sep_count_ff;
      is_sep    = 1'b0;
      for (int i = 0; i < MAX_SEPARATORS; i++) begin
         if (4'(i) < sep_limit && sep_bytes_ff[8 * i +: 8] == c) begin
            is_sep = 1'b1;
         end
      end
      is_sep  = is_sep && !is_blank;
      pending = (length_ff != 8'd0);

      cc = char_codes(c, first_version_ff);

      // A separator starts a fresh token; any other byte extends the pending word.
      tok_base      = is_sep ? {ZCHARS_PER_WORD{PAD_CODE}} : zbuf_ff;
      tok_fill_base = is_sep ? '0 : fill_ff;
      tok_buf       = merge(tok_base, tok_fill_base, cc);
      fill_sum      = {1'b0, tok_fill_base} + (FILL_W + 1)'(cc.count);
      tok_fill      = (fill_sum > (FILL_W + 1)'(ZCHARS_PER_WORD)) ?
                      FILL_W'(ZCHARS_PER_WORD) : fill_sum[FILL_W-1:0];
      tok_length    = is_sep ? 8'd1 : ((length_ff == 8'hFF) ? 8'hFF : length_ff + 8'd1);
      tok_start     = (is_sep || !pending) ? pos : start_ff;

      pend_item.packed_code    = pack_word(zbuf_ff);
      pend_item.word_length    = length_ff;
      pend_item.start_position = start_ff;
      pend_item.last_of_run    = 1'b0;

      tok_item.packed_code    = pack_word(tok_buf);
      tok_item.word_length    = tok_length;
      tok_item.start_position = tok_start;
      tok_item.last_of_run    = 1'b0;

      res0 = pend_item;
      res1 = tok_item;
      nres = 2'd0;
      if (is_blank) begin
         nres = pending ? 2'd1 : 2'd0;
      end else if (is_sep) begin
         if (pending) begin
            nres = 2'd2;
         end else begin
            res0 = tok_item;
            nres = 2'd1;
         end
      end else if (req.end_of_line) begin
         res0 = tok_item;
         nres = 2'd1;
      end
      res0.last_of_run = (nres == 2'd1);
      res1.last_of_run = 1'b1;

      // Word state follows every accepted byte.
      clear_word  = is_blank || is_sep || req.end_of_line;
      zbuf_in     = zbuf_ff;
      fill_in     = fill_ff;
      length_in   = length_ff;
      start_in    = start_ff;
      line_pos_in = line_pos_ff;
      if (req_beat) begin
         line_pos_in = req.end_of_line ? 8'd0 : pos;
         if (clear_word) begin
            zbuf_in   = {ZCHARS_PER_WORD{PAD_CODE}};
            fill_in   = '0;
            length_in = 8'd0;
            start_in  = 8'd0;
         end else begin
            zbuf_in   = tok_buf;
            fill_in   = tok_fill;
            length_in = tok_length;
            start_in  = tok_start;
         end
      end

      // Queue: shift out on a taken beat, then append the new results.
      base_count = count_ff - (rsp_beat ? 3'd1 : 3'd0);
      for (int i = 0; i < QDEPTH; i++) begin
         if (rsp_beat) begin
            q_in[i] = (i + 1 < QDEPTH) ? q_ff[(i + 1) % QDEPTH] : q_ff[i];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (req_beat && nres != 2'd0 && 3'(i) == base_count) begin
            q_in[i] = res0;
         end
         if (req_beat && nres == 2'd2 && 3'(i) == base_count + 3'd1) begin
            q_in[i] = res1;
         end
      end
      count_in = base_count + (req_beat ? {1'b0, nres} : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_bytes_ff     <= '0;
         sep_count_ff     <= '0;
         first_version_ff <= 1'b0;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_SEPARATOR_BYTES: sep_bytes_ff     <= csr.data;
            CSR_SEPARATOR_COUNT: sep_count_ff     <= csr.data[3:0];
            CSR_FIRST_VERSION:   first_version_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zbuf_ff     <= {ZCHARS_PER_WORD{PAD_CODE}};
         fill_ff     <= '0;
         length_ff   <= '0;
         start_ff    <= '0;
         line_pos_ff <= '0;
         count_ff    <= '0;
      end else begin
         zbuf_ff     <= zbuf_in;
         fill_ff     <= fill_in;
         length_ff   <= length_in;
         start_ff    <= start_in;
         line_pos_ff <= line_pos_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule
